[rtl/ipru_pkg.sv]
package ipru_pkg;

  // input item as seen on the push side
  typedef struct packed {
    logic       operation;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_item_t;

  // result item as seen on the pop side
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       row_end;
    logic       image_end;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    logic        is_drain;
    logic [23:0] pixel;
  } cmd_t;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PIXEL   = 2'd1;
  localparam logic [1:0] KIND_PAD     = 2'd2;
  localparam logic [1:0] KIND_REFUSED = 2'd3;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd2;

  // register widths
  localparam int SCALE_W  = 7;
  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 16;

  // largest scale honored; larger values saturate
  localparam logic [SCALE_W-1:0] SCALE_LIMIT = 7'd100;

  // depth of the command queue and the result queue
  localparam int QUEUE_DEPTH = 4;

endpackage

[rtl/integer_pixel_replication_upscaler_top.sv]
// Integer pixel replication upscaler. Push one item per clock while in_full
// is low: a load writes a 24-bit source pixel into a MAX_WIDTH-entry line
// store, a drain tick steps the enlarged row out (each pixel repeated scale
// times, then (width*scale) mod 4 zero padding bytes, the whole row repeated
// scale times). Every item gives exactly one result item, in order; loads
// during a drain come back as refused. The sustained rate is one item per
// clock on both sides while the consumer pops every result; an accepted item
// passes through the front register, the four-entry command queue and the
// execute stage with the line store read and result register into the result
// queue, from which it is popped. The line store has one write and one
// registered read port and needs no clearing after reset. Write configuration
// only while the block is idle.
module integer_pixel_replication_upscaler_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  ipru_pkg::in_item_t                in_item,
  output logic                              in_full,
  input  logic                              out_pop,
  output ipru_pkg::out_item_t               out_item,
  output logic                              out_empty,
  input  logic                              cfg_we,
  input  logic [ipru_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ipru_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CMD_W = $bits(ipru_pkg::cmd_t);
  localparam int RES_W = $bits(ipru_pkg::out_item_t);
  localparam int NW    = $clog2(ipru_pkg::QUEUE_DEPTH + 1);

  logic                q_push, q_full, q_pop, q_empty;
  ipru_pkg::cmd_t      q_wr_cmd, q_rd_cmd;
  logic [CMD_W-1:0]    q_rd_bits;
  logic [NW-1:0]       q_count;
  logic                res_push, res_full;
  ipru_pkg::out_item_t res_item;
  logic [RES_W-1:0]    res_rd_bits;
  logic [NW-1:0]       res_count;

  // accept and classify
  ipru_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_wr_cmd)
  );

  // command queue between front and back
  ipru_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (ipru_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_bits),
    .empty   (q_empty),
    .count   (q_count)
  );

  assign q_rd_cmd = ipru_pkg::cmd_t'(q_rd_bits);

  // row sequencing and line store
  ipru_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty && (q_count == '0)),
    .q_cmd     (q_rd_cmd),
    .q_pop     (q_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  // result queue toward the consumer
  ipru_fifo #(
    .WIDTH (RES_W),
    .DEPTH (ipru_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_rd_bits),
    .empty   (out_empty),
    .count   (res_count)
  );

  assign out_item = ipru_pkg::out_item_t'(res_rd_bits);

endmodule

[rtl/ipru_fifo.sv]
module ipru_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wr_data,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == NW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = store_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and count update with wrap at depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/ipru_front.sv]
module ipru_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  ipru_pkg::in_item_t in_item,
  output logic              in_full,
  input  logic              q_full,
  output logic              q_push,
  output ipru_pkg::cmd_t    q_cmd
);

  logic           valid_r, valid_nxt;
  ipru_pkg::cmd_t cmd_r;
  ipru_pkg::cmd_t cmd_class;
  logic           accept;

  // hand the held item to the queue whenever it has room
  assign q_push  = valid_r && !q_full;
  assign q_cmd   = cmd_r;
  assign in_full = valid_r && q_full;
  assign accept  = in_push && !in_full;

  // classify the item and pack the pixel
  always_comb begin
    cmd_class.is_drain = (in_item.operation == ipru_pkg::OP_DRAIN);
    cmd_class.pixel    = {in_item.in_red, in_item.in_green, in_item.in_blue};
  end

  assign valid_nxt = accept || (valid_r && !q_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_class;
    end
  end

endmodule

[rtl/ipru_back.sv]
module ipru_back #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [ipru_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [ipru_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    q_empty,
  input  ipru_pkg::cmd_t                          q_cmd,
  output logic                                    q_pop,
  input  logic [$clog2(ipru_pkg::QUEUE_DEPTH+1)-1:0] res_count,
  output logic                                    res_push,
  output ipru_pkg::out_item_t                     res_item
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int SW = ipru_pkg::SCALE_W;
  localparam int HW = ipru_pkg::HEIGHT_W;

  // configuration registers
  logic [SW-1:0]                scale_r;
  logic [ipru_pkg::WIDTH_W-1:0] width_r;
  logic [HW-1:0]                height_r;

  // sequencing state
  logic          draining_r, draining_nxt;
  logic [CW-1:0] load_col_r, load_col_nxt;
  logic [CW-1:0] read_col_r, read_col_nxt;
  logic [SW-1:0] across_r, across_nxt;
  logic [SW-1:0] down_r, down_nxt;
  logic [1:0]    pad_r, pad_nxt;
  logic [HW-1:0] row_r, row_nxt;

  // line store and result stage
  logic [23:0]   line_mem [MAX_WIDTH];
  logic [23:0]   rd_data_r;
  logic          s2_valid_r;
  logic [1:0]    s2_kind_r;
  logic          s2_rend_r, s2_iend_r;

  // stage one decode
  logic          issue;
  logic [SW-1:0] s_eff;
  logic [31:0]   w_raw;
  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] lc_inc, rc_inc;
  logic [SW:0]   ar_inc, dr_inc;
  logic [HW:0]   row_inc;
  logic [1:0]    pad_calc;
  logic [1:0]    kind;
  logic          rend, iend;
  logic          wr_en, rd_en;
  logic          end_row, do_finish;

  // issue only when the result queue can take everything in flight
  assign issue = !q_empty &&
                 ((32'(res_count) + 32'(s2_valid_r)) < 32'(ipru_pkg::QUEUE_DEPTH));
  assign q_pop = issue;

  // effective register values
  always_comb begin
    s_eff = (scale_r > ipru_pkg::SCALE_LIMIT) ? ipru_pkg::SCALE_LIMIT : scale_r;
    w_raw = 32'(width_r);
    if (width_r == '0) begin
      w_raw = 32'd1;
    end
    if (w_raw > 32'(MAX_WIDTH)) begin
      w_raw = 32'(MAX_WIDTH);
    end
    w_eff = w_raw[CW-1:0];
    h_eff = (height_r == '0) ? HW'(1) : height_r;
  end

  assign lc_inc   = load_col_r + 1'b1;
  assign rc_inc   = read_col_r + 1'b1;
  assign ar_inc   = {1'b0, across_r} + 1'b1;
  assign dr_inc   = {1'b0, down_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  // bytes of padding: low two bits of width times scale
  assign pad_calc = 2'(w_eff[1:0] * s_eff[1:0]);

  // execute one command against the row state
  always_comb begin
    draining_nxt = draining_r;
    load_col_nxt = load_col_r;
    read_col_nxt = read_col_r;
    across_nxt   = across_r;
    down_nxt     = down_r;
    pad_nxt      = pad_r;
    row_nxt      = row_r;
    kind         = ipru_pkg::KIND_NONE;
    rend         = 1'b0;
    iend         = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    end_row      = 1'b0;
    do_finish    = 1'b0;

    if (issue) begin
      if (!q_cmd.is_drain) begin
        // load a source pixel
        if (draining_r) begin
          kind = ipru_pkg::KIND_REFUSED;
        end else begin
          wr_en = (32'(load_col_r) < 32'(MAX_WIDTH));
          if (lc_inc >= w_eff) begin
            if (s_eff == '0) begin
              do_finish = 1'b1;
            end else begin
              load_col_nxt = '0;
              draining_nxt = 1'b1;
              read_col_nxt = '0;
              across_nxt   = '0;
              down_nxt     = '0;
              pad_nxt      = '0;
            end
          end else begin
            load_col_nxt = lc_inc;
          end
        end
      end else if (draining_r) begin
        // drain tick
        if (s_eff == '0) begin
          do_finish = 1'b1;
        end else if (pad_r != '0) begin
          kind    = ipru_pkg::KIND_PAD;
          pad_nxt = pad_r - 1'b1;
          if (pad_r == 2'd1) begin
            rend    = 1'b1;
            end_row = 1'b1;
          end
        end else begin
          kind  = ipru_pkg::KIND_PIXEL;
          rd_en = 1'b1;
          if (ar_inc >= {1'b0, s_eff}) begin
            across_nxt = '0;
            if (rc_inc >= w_eff) begin
              if (pad_calc == '0) begin
                rend    = 1'b1;
                end_row = 1'b1;
              end else begin
                pad_nxt      = pad_calc;
                read_col_nxt = '0;
              end
            end else begin
              read_col_nxt = rc_inc;
            end
          end else begin
            across_nxt = ar_inc[SW-1:0];
          end
        end
      end
    end

    // end of one output row
    if (end_row) begin
      read_col_nxt = '0;
      across_nxt   = '0;
      pad_nxt      = '0;
      if (dr_inc >= {1'b0, s_eff}) begin
        do_finish = 1'b1;
      end else begin
        down_nxt = dr_inc[SW-1:0];
      end
    end

    // end of one source row
    if (do_finish) begin
      draining_nxt = 1'b0;
      load_col_nxt = '0;
      read_col_nxt = '0;
      across_nxt   = '0;
      down_nxt     = '0;
      pad_nxt      = '0;
      if (row_inc >= {1'b0, h_eff}) begin
        row_nxt = '0;
        iend    = end_row;
      end else begin
        row_nxt = row_inc[HW-1:0];
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SW'(1);
      width_r  <= ipru_pkg::WIDTH_W'(1);
      height_r <= HW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        ipru_pkg::CFG_SCALE:  scale_r  <= cfg_data[SW-1:0];
        ipru_pkg::CFG_WIDTH:  width_r  <= cfg_data[ipru_pkg::WIDTH_W-1:0];
        ipru_pkg::CFG_HEIGHT: height_r <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // row state and result stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r <= 1'b0;
      load_col_r <= '0;
      read_col_r <= '0;
      across_r   <= '0;
      down_r     <= '0;
      pad_r      <= '0;
      row_r      <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      draining_r <= draining_nxt;
      load_col_r <= load_col_nxt;
      read_col_r <= read_col_nxt;
      across_r   <= across_nxt;
      down_r     <= down_nxt;
      pad_r      <= pad_nxt;
      row_r      <= row_nxt;
      s2_valid_r <= issue;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (issue) begin
      s2_kind_r <= kind;
      s2_rend_r <= rend;
      s2_iend_r <= iend;
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[load_col_r[AW-1:0]] <= q_cmd.pixel;
    end
    if (rd_en) begin
      rd_data_r <= line_mem[read_col_r[AW-1:0]];
    end
  end

  // form the result item
  always_comb begin
    res_item.kind      = s2_kind_r;
    res_item.row_end   = s2_rend_r;
    res_item.image_end = s2_iend_r;
    if (s2_kind_r == ipru_pkg::KIND_PIXEL) begin
      res_item.out_red   = rd_data_r[23:16];
      res_item.out_green = rd_data_r[15:8];
      res_item.out_blue  = rd_data_r[7:0];
    end else begin
      res_item.out_red   = '0;
      res_item.out_green = '0;
      res_item.out_blue  = '0;
    end
  end

  assign res_push = s2_valid_r;

endmodule
